// ===== rtl/tcar_pkg.sv =====
package tcar_pkg;

    localparam int PIXELS = 8;

    typedef logic [4:0] t_pix;
    typedef logic [3:0] t_nib;

    typedef enum logic [1:0] {
        CFG_BLINK_ENABLE     = 2'd0,
        CFG_MONO_ATTRIBUTES  = 2'd1,
        CFG_ENHANCED_VARIANT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic blink_enable;
        logic mono_attributes;
        logic enhanced_variant;
    } t_cfg;

    localparam logic [7:0] ATTR_REVERSE_LO  = 8'h70;
    localparam logic [7:0] ATTR_REVERSE_HI  = 8'hF0;
    localparam logic [7:0] ATTR_BRIGHT_LO   = 8'h78;
    localparam logic [7:0] ATTR_BRIGHT_HI   = 8'hF8;
    localparam logic [7:0] ATTR_HIDDEN_A    = 8'h00;
    localparam logic [7:0] ATTR_HIDDEN_B    = 8'h08;
    localparam logic [7:0] ATTR_HIDDEN_C    = 8'h80;
    localparam logic [7:0] ATTR_HIDDEN_D    = 8'h88;
    localparam logic [2:0] ATTR_UNDERLINE   = 3'b001;
    localparam logic [4:0] UNDERLINE_ROW    = 5'd12;

    // palette indices 16..31 are the low nibble with bit 4 set
    localparam t_nib NIB_BLACK  = 4'h0;
    localparam t_nib NIB_NORMAL = 4'h7;
    localparam t_nib NIB_BRIGHT = 4'hF;
    localparam t_nib CURSOR_XOR = 4'hF;

endpackage

// ===== rtl/tcar_decode.sv =====
module tcar_decode
    import tcar_pkg::*;
(
    input  t_cfg       i_cfg,
    input  logic [7:0] i_font_row,
    input  logic [7:0] i_attribute,
    input  logic       i_cursor_here,
    input  logic       i_blink_phase,
    input  logic [4:0] i_scanline,
    output t_pix       o_pixel [PIXELS]
);

    logic blinking;
    logic mono;
    logic underline;
    logic is_reverse;
    logic is_bright;
    logic is_hidden;
    t_nib mono_fg;
    t_nib mono_bg;
    t_nib fg;
    t_nib bg;

    assign blinking = i_cfg.blink_enable && i_blink_phase && i_attribute[7] && !i_cursor_here;
    assign mono     = i_cfg.enhanced_variant && i_cfg.mono_attributes;

    assign is_reverse = (i_attribute == ATTR_REVERSE_LO) || (i_attribute == ATTR_REVERSE_HI);
    assign is_bright  = (i_attribute == ATTR_BRIGHT_LO) || (i_attribute == ATTR_BRIGHT_HI);
    assign is_hidden  = i_attribute inside {ATTR_HIDDEN_A, ATTR_HIDDEN_B,
                                            ATTR_HIDDEN_C, ATTR_HIDDEN_D};

    // monochrome attribute map
    always_comb begin
        if (is_reverse || is_bright) begin
            mono_bg = NIB_BRIGHT;
            if (blinking) begin
                mono_fg = NIB_BRIGHT;
            end else if (is_bright) begin
                mono_fg = NIB_NORMAL;
            end else begin
                mono_fg = NIB_BLACK;
            end
        end else begin
            mono_bg = NIB_BLACK;
            if (blinking || is_hidden) begin
                mono_fg = NIB_BLACK;
            end else if (i_attribute[3]) begin
                mono_fg = NIB_BRIGHT;
            end else begin
                mono_fg = NIB_NORMAL;
            end
        end
    end

    always_comb begin
        underline = 1'b0;
        if (mono) begin
            fg        = mono_fg;
            bg        = mono_bg;
            underline = (i_scanline == UNDERLINE_ROW) && (i_attribute[2:0] == ATTR_UNDERLINE);
        end else if (i_cfg.blink_enable) begin
            bg = {1'b0, i_attribute[6:4]};
            fg = blinking ? {1'b0, i_attribute[6:4]} : i_attribute[3:0];
        end else begin
            fg = i_attribute[3:0];
            bg = i_attribute[7:4];
        end
    end

    always_comb begin
        for (int i = 0; i < PIXELS; i++) begin
            if (underline) begin
                o_pixel[i] = {1'b1, fg};
            end else if (i_font_row[PIXELS-1-i]) begin
                o_pixel[i] = {1'b1, fg ^ (i_cursor_here ? CURSOR_XOR : NIB_BLACK)};
            end else begin
                o_pixel[i] = {1'b1, bg ^ (i_cursor_here ? CURSOR_XOR : NIB_BLACK)};
            end
        end
    end

endmodule

// ===== rtl/text_cell_attribute_renderer.sv =====
// text cell attribute renderer
//
// input channel: one beat per character cell row (font row byte, attribute,
// cursor flag, blink phase, scanline), i_in_valid / o_in_stall.
// output channel: one beat of eight palette indices 16..31, leftmost pixel
// first, o_out_valid / i_out_stall.
// configuration: i_cfg_we writes i_cfg_data[0] to the mode bit chosen by
// i_cfg_index (0 blink enable, 1 mono attributes, 2 enhanced variant);
// other indices are ignored. write only while no beat is in flight.
// pipeline: input register, then decode into the result register.
// throughput: one beat per cycle while i_out_stall is low, set by
// the single decode pass between the two registers.
// reset: mode bits clear to 0, both stages empty, no output beat.
// stall: while i_out_stall holds, the result register holds its beat; the
// input register still takes one more beat, after which o_in_stall rises
// until the output drains.
module text_cell_attribute_renderer
    import tcar_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [0:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_font_row,
    input  logic [7:0] i_attribute,
    input  logic       i_cursor_here,
    input  logic       i_blink_phase,
    input  logic [4:0] i_scanline,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_pixel_0,
    output logic [4:0] o_pixel_1,
    output logic [4:0] o_pixel_2,
    output logic [4:0] o_pixel_3,
    output logic [4:0] o_pixel_4,
    output logic [4:0] o_pixel_5,
    output logic [4:0] o_pixel_6,
    output logic [4:0] o_pixel_7
);

    t_cfg       r_cfg;
    logic       r_s1_valid;
    logic       r_out_valid;
    logic [7:0] r_font_row;
    logic [7:0] r_attribute;
    logic       r_cursor_here;
    logic       r_blink_phase;
    logic [4:0] r_scanline;
    t_pix       r_pix [PIXELS];
    t_pix       n_pix [PIXELS];
    logic       s1_advance;
    logic       in_accept;

    assign s1_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    tcar_decode u_decode (
        .i_cfg         (r_cfg),
        .i_font_row    (r_font_row),
        .i_attribute   (r_attribute),
        .i_cursor_here (r_cursor_here),
        .i_blink_phase (r_blink_phase),
        .i_scanline    (r_scanline),
        .o_pixel       (n_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLINK_ENABLE:     r_cfg.blink_enable     <= i_cfg_data[0];
                    CFG_MONO_ATTRIBUTES:  r_cfg.mono_attributes  <= i_cfg_data[0];
                    CFG_ENHANCED_VARIANT: r_cfg.enhanced_variant <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_font_row    <= i_font_row;
            r_attribute   <= i_attribute;
            r_cursor_here <= i_cursor_here;
            r_blink_phase <= i_blink_phase;
            r_scanline    <= i_scanline;
        end
        if (s1_advance && r_s1_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_pixel_0 = r_pix[0];
    assign o_pixel_1 = r_pix[1];
    assign o_pixel_2 = r_pix[2];
    assign o_pixel_3 = r_pix[3];
    assign o_pixel_4 = r_pix[4];
    assign o_pixel_5 = r_pix[5];
    assign o_pixel_6 = r_pix[6];
    assign o_pixel_7 = r_pix[7];

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("beat in input register lost during stall");

    a_beat_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_advance) |=> r_out_valid)
        else $error("decoded beat did not reach output register");

    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_pixel_0[4] && o_pixel_3[4] && o_pixel_7[4]))
        else $error("palette index below 16");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import tcar_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_PER_MODE = 112;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    localparam t_pix SHADE_OFF    = {1'b1, NIB_BLACK};
    localparam t_pix SHADE_NORMAL = {1'b1, NIB_NORMAL};
    localparam t_pix SHADE_BRIGHT = {1'b1, NIB_BRIGHT};

    typedef t_pix [PIXELS-1:0] t_row;

    typedef struct packed {
        logic [7:0] font;
        logic [7:0] attr;
        logic       cursor;
        logic       phase;
        logic [4:0] line;
    } t_cell;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [0:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_font_row = '0;
    logic [7:0] i_attribute = '0;
    logic       i_cursor_here = 1'b0;
    logic       i_blink_phase = 1'b0;
    logic [4:0] i_scanline = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [4:0] o_pixel_0, o_pixel_1, o_pixel_2, o_pixel_3;
    logic [4:0] o_pixel_4, o_pixel_5, o_pixel_6, o_pixel_7;

    text_cell_attribute_renderer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_font_row    (i_font_row),
        .i_attribute   (i_attribute),
        .i_cursor_here (i_cursor_here),
        .i_blink_phase (i_blink_phase),
        .i_scanline    (i_scanline),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_0     (o_pixel_0),
        .o_pixel_1     (o_pixel_1),
        .o_pixel_2     (o_pixel_2),
        .o_pixel_3     (o_pixel_3),
        .o_pixel_4     (o_pixel_4),
        .o_pixel_5     (o_pixel_5),
        .o_pixel_6     (o_pixel_6),
        .o_pixel_7     (o_pixel_7)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cfg  mode_bits = '0;
    t_cell pending_cells[$];
    t_row  expected_rows[$];
    int    cycle_count = 0;
    int    mismatch_count = 0;
    int    cells_accepted = 0;
    int    rows_checked = 0;
    int    modes_run = 0;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // monochrome attribute map, fore selects the foreground entry
    function automatic t_pix mono_shade(logic [7:0] a, logic blinking, logic fore);
        if (a == ATTR_REVERSE_LO || a == ATTR_REVERSE_HI) begin
            if (blinking) return SHADE_BRIGHT;
            return fore ? SHADE_OFF : SHADE_BRIGHT;
        end
        if (a == ATTR_BRIGHT_LO || a == ATTR_BRIGHT_HI) begin
            if (blinking) return SHADE_BRIGHT;
            return fore ? SHADE_NORMAL : SHADE_BRIGHT;
        end
        if (!fore || blinking) return SHADE_OFF;
        if (a == ATTR_HIDDEN_A || a == ATTR_HIDDEN_B || a == ATTR_HIDDEN_C ||
            a == ATTR_HIDDEN_D) return SHADE_OFF;
        return a[3] ? SHADE_BRIGHT : SHADE_NORMAL;
    endfunction

    function automatic t_row render_cell(t_cell c);
        t_row px;
        t_pix fg;
        t_pix bg;
        logic blinking;
        logic underline;
        blinking = mode_bits.blink_enable && c.phase && c.attr[7] && !c.cursor;
        underline = 1'b0;
        if (mode_bits.enhanced_variant && mode_bits.mono_attributes) begin
            bg = mono_shade(c.attr, blinking, 1'b0);
            fg = mono_shade(c.attr, blinking, 1'b1);
            underline = (c.line == UNDERLINE_ROW) && (c.attr[2:0] == ATTR_UNDERLINE);
        end else if (mode_bits.blink_enable) begin
            fg = {1'b1, c.attr[3:0]};
            bg = {2'b10, c.attr[6:4]};
            if (blinking) fg = bg;
        end else begin
            fg = {1'b1, c.attr[3:0]};
            bg = {1'b1, c.attr[7:4]};
        end
        for (int i = 0; i < PIXELS; i++) begin
            if (underline) begin
                px[i] = fg;
            end else begin
                px[i] = c.font[7-i] ? fg : bg;
                if (c.cursor) px[i] = px[i] ^ {1'b0, CURSOR_XOR};
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < 40) $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // driver: bursts of beats with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_cell c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                c.font = i_font_row;
                c.attr = i_attribute;
                c.cursor = i_cursor_here;
                c.phase = i_blink_phase;
                c.line = i_scanline;
                expected_rows.push_back(render_cell(c));
                cells_accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cells.size() > 0) begin
                c = pending_cells.pop_front();
                i_in_valid <= 1'b1;
                i_font_row <= c.font;
                i_attribute <= c.attr;
                i_cursor_here <= c.cursor;
                i_blink_phase <= c.phase;
                i_scanline <= c.line;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                          : $urandom_range(8);
                    gap_left = $urandom_range(7);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each output beat, stalls on a changing pattern
    int hold_mode = 0;
    int hold_span = 0;
    int hold_tick = 0;

    always @(posedge i_clk) begin
        t_row got;
        t_row want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4,
                       o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0};
                if (expected_rows.size() == 0) begin
                    report_mismatch("output beat with nothing expected");
                end else begin
                    want = expected_rows.pop_front();
                    for (int i = 0; i < PIXELS; i++) begin
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("row %0d pixel %0d: got %0d want %0d",
                                rows_checked, i, got[i], want[i]));
                    end
                    rows_checked++;
                end
            end
            if (hold_span == 0) begin
                hold_mode = $urandom_range(3);
                hold_span = $urandom_range(96, 16);
            end else begin
                hold_span--;
            end
            hold_tick++;
            case (hold_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(3) == 0);
                2: i_out_stall <= ($urandom_range(3) != 0);
                default: i_out_stall <= (hold_tick % 3 == 0);
            endcase
        end
    end

    task automatic queue_cell(logic [7:0] font, logic [7:0] attr, logic cursor,
                              logic phase, logic [4:0] line);
        t_cell c;
        c.font = font;
        c.attr = attr;
        c.cursor = cursor;
        c.phase = phase;
        c.line = line;
        pending_cells.push_back(c);
    endtask

    task automatic queue_random_cell();
        logic [31:0] r;
        logic [7:0] attr;
        r = $urandom;
        case ($urandom_range(15))
            0: attr = ATTR_REVERSE_LO;
            1: attr = ATTR_REVERSE_HI;
            2: attr = ATTR_BRIGHT_LO;
            3: attr = ATTR_BRIGHT_HI;
            4: attr = ATTR_HIDDEN_A;
            5: attr = ATTR_HIDDEN_B;
            6: attr = ATTR_HIDDEN_C;
            7: attr = ATTR_HIDDEN_D;
            8, 9: attr = {r[12:8], ATTR_UNDERLINE};
            default: attr = r[7:0];
        endcase
        queue_cell(8'($urandom_range(255)), attr, $urandom_range(3) == 0,
                   1'($urandom_range(1)), ($urandom_range(3) == 0) ? UNDERLINE_ROW
                                                                   : 5'($urandom_range(31)));
    endtask

    task automatic wait_idle();
        while (pending_cells.size() != 0 || i_in_valid || expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] idx, logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLINK_ENABLE:     mode_bits.blink_enable = val;
            CFG_MONO_ATTRIBUTES:  mode_bits.mono_attributes = val;
            CFG_ENHANCED_VARIANT: mode_bits.enhanced_variant = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(logic blink, logic mono, logic enh);
        wait_idle();
        write_mode(CFG_BLINK_ENABLE, blink);
        write_mode(CFG_MONO_ATTRIBUTES, mono);
        write_mode(CFG_ENHANCED_VARIANT, enh);
        // out-of-range index must leave the mode bits alone
        write_mode(CFG_UNUSED_IDX, 1'($urandom_range(1)));
        modes_run++;
    endtask

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        logic [2:0] bits;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode: colour, no blink
        queue_cell(8'h00, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_cell(8'hFF, 8'hFF, 1'b0, 1'b1, 5'd31);
        queue_cell(8'h80, 8'h0F, 1'b1, 1'b0, 5'd0);
        queue_cell(8'h01, 8'hF0, 1'b1, 1'b1, 5'd31);
        queue_cell(8'hA5, 8'h5A, 1'b0, 1'b1, UNDERLINE_ROW);

        // blink without mono map, cursor suppresses blink
        set_mode(1'b1, 1'b0, 1'b0);
        queue_cell(8'h3C, 8'h8F, 1'b0, 1'b1, 5'd3);
        queue_cell(8'h3C, 8'h8F, 1'b1, 1'b1, 5'd3);

        // mono bit ignored on the plain variant
        set_mode(1'b0, 1'b1, 1'b0);
        queue_cell(8'h0F, ATTR_REVERSE_LO, 1'b0, 1'b0, 5'd4);
        queue_cell(8'h00, 8'h01, 1'b0, 1'b0, UNDERLINE_ROW);

        // mono map with blink
        set_mode(1'b1, 1'b1, 1'b1);
        queue_cell(8'hC3, ATTR_REVERSE_LO, 1'b0, 1'b0, 5'd0);
        queue_cell(8'hC3, ATTR_REVERSE_HI, 1'b0, 1'b1, 5'd1);
        queue_cell(8'hC3, ATTR_REVERSE_HI, 1'b1, 1'b1, 5'd1);
        queue_cell(8'h5A, ATTR_BRIGHT_LO, 1'b0, 1'b0, 5'd2);
        queue_cell(8'h5A, ATTR_BRIGHT_HI, 1'b0, 1'b1, 5'd2);
        queue_cell(8'hFF, ATTR_HIDDEN_A, 1'b0, 1'b0, 5'd5);
        queue_cell(8'hFF, ATTR_HIDDEN_B, 1'b1, 1'b0, 5'd5);
        queue_cell(8'hFF, ATTR_HIDDEN_C, 1'b0, 1'b0, 5'd5);
        queue_cell(8'hFF, ATTR_HIDDEN_D, 1'b0, 1'b1, 5'd5);
        queue_cell(8'h00, 8'h01, 1'b0, 1'b0, UNDERLINE_ROW);
        queue_cell(8'h00, 8'h89, 1'b1, 1'b1, UNDERLINE_ROW);
        queue_cell(8'h00, 8'h81, 1'b0, 1'b1, UNDERLINE_ROW);
        queue_cell(8'h00, 8'h09, 1'b0, 1'b0, 5'd11);
        queue_cell(8'hAA, 8'h0F, 1'b0, 1'b0, 5'd7);
        queue_cell(8'h55, 8'h07, 1'b1, 1'b0, 5'd7);

        for (int m = 0; m < 12; m++) begin
            bits = (m < 8) ? 3'(m) : 3'($urandom_range(7));
            set_mode(bits[0], bits[1], bits[2]);
            for (int k = 0; k < RANDOM_PER_MODE; k++) queue_random_cell();
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_rows.size() != 0) report_mismatch("rows still expected at end");
        $display("summary: %0d cells rendered, %0d rows checked, %0d mode settings",
                 cells_accepted, rows_checked, modes_run + 1);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
